[src/wvp_pkg.sv]
// Shared types and constants for the wavetable voice playback core.
// Holds the item structs, operation and register codes and the sequencer states.
// No dependencies.
`default_nettype none
package wvp_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int SMP_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int LOOP_W     = 24;
	localparam int RATE_W     = 24;
	localparam int LEN_W      = 17;
	localparam int VEL_W      = 7;
	localparam int FADE_W     = 16;
	localparam int GAIN_W     = 15;
	localparam int GAIN_SHIFT = 15;

	localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;
	localparam logic [VEL_W-1:0]  VEL_RESET  = 7'd127;

	// Gain = (196608 * velocity + 635) / 1270, i.e. 0.6 * velocity / 127 in Q15, rounded.
	localparam int GAIN_SCALE = 196608;
	localparam int GAIN_BIAS  = 635;
	localparam int GAIN_DIV   = 1270;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_START   = 2'd1,
		OP_TICK    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOP_ENABLE    = 3'd0,
		CFG_LOOP_START     = 3'd1,
		CFG_LOOP_END       = 3'd2,
		CFG_SAMPLE_LENGTH  = 3'd3,
		CFG_RATE_RATIO     = 3'd4,
		CFG_NOTE_VELOCITY  = 3'd5,
		CFG_SOFT_MODE      = 3'd6,
		CFG_IGNORE_RELEASE = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_WRAP_WAIT,
		ST_GAIN,
		ST_GAIN_WAIT,
		ST_CHECK,
		ST_RD0,
		ST_RD1,
		ST_MUL1,
		ST_SUM,
		ST_MUL2,
		ST_RND,
		ST_FMUL,
		ST_FDIV,
		ST_FDIV_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [15:0]       address;
		logic signed [15:0] load_left;
		logic signed [15:0] load_right;
		logic [15:0]       release_length;
		logic              sustain_held;
	} req_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic              note_active;
	} rsp_t;

endpackage
`default_nettype wire

[src/wvp_ram.sv]
// Generic single-port RAM with registered read data.
// One address per cycle; a write cycle also reads back the old word. No dependencies.
`default_nettype none
module wvp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[src/wvp_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used for the loop wrap remainder, the gain and the release fade. No dependencies.
`default_nettype none
module wvp_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic      [W-1:0] quot,
	output logic      [W-1:0] rem
);

	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quot_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       r_sh;
	logic [W:0]       diff;

	assign r_sh = {rem_q, quot_q[W-1]};
	assign diff = r_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q  <= diff[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= r_sh[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

[src/wavetable_voice_playback_core.sv]
// Top level of one wavetable voice: sample stores, sequencer and serial arithmetic.
// Depends on wvp_pkg, wvp_ram and wvp_div.
//
// Load, start and release items are handled as they are taken and leave the sequencer idle.
// A tick runs the optional loop wrap, the gain divide, the end check, two sample reads, the
// interpolation multiply, the gain multiply and rounding, and while the note fades after
// release a fade multiply and a divide per channel. It uses the one-bit-per-cycle divider
// (gain, loop wrap and fade) and the shift-add multiplier that serves both channels in
// parallel. A tick while the voice is silent goes straight to the finish state and presents
// a zero result. The input is stalled while a tick is in progress; a finished result sits
// in an output register, so the next item is taken while it waits.
`default_nettype none
module wavetable_voice_playback_core import wvp_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int POS_W   = ADDR_BITS + FRAC_BITS;
	localparam int IDX_W   = (ADDR_BITS > 16) ? ADDR_BITS : 16;
	localparam int LW      = IDX_W + FRAC_BITS;
	localparam int DW      = (LW > 32) ? LW : 32;
	localparam int XW      = (FRAC_BITS > 16) ? FRAC_BITS : 16;
	localparam int MW      = FRAC_BITS + 33;
	localparam int S_W     = FRAC_BITS + 18;
	localparam int Y_W     = 17;
	localparam int CW      = ((IDX_W > 17) ? IDX_W : 17) + 1;
	localparam int RATE_UP = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
	localparam int RATE_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int STEP_W  = RATE_W + RATE_UP;
	localparam int SH0     = GAIN_SHIFT + FRAC_BITS;
	localparam int XCNT_W  = $clog2(XW);

	// Configuration registers.
	logic              loop_en_q;
	logic [LOOP_W-1:0] loop_start_q;
	logic [LOOP_W-1:0] loop_end_q;
	logic [LEN_W-1:0]  smp_len_q;
	logic [RATE_W-1:0] rate_q;
	logic [VEL_W-1:0]  vel_q;
	logic              soft_q;
	logic              ign_rel_q;

	// Voice state.
	state_t            state_q, state_d;
	logic [POS_W-1:0]  pos_q;
	logic              playing_q;
	logic              releasing_q;
	logic [FADE_W-1:0] fade_cnt_q;
	logic [FADE_W-1:0] fade_len_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// Tick working registers.
	logic [LW-1:0]       pos_w_q;
	logic [GAIN_W-1:0]   gain_q;
	logic                fade_q;
	logic                active_q;
	logic [SMP_W-1:0]    a_q   [2];
	logic                dneg_q[2];
	logic                sgn_q [2];
	logic [MW-1:0]       mc_q  [2];
	logic [MW-1:0]       acc_q [2];
	logic [Y_W-1:0]      ymag_q[2];
	logic [XW-1:0]       x_q;
	logic [XCNT_W-1:0]   xcnt_q;
	logic                ch_q;

	logic                  accept;
	logic                  load_we;
	logic [ADDR_BITS-1:0]  ram_addr;
	logic [SMP_W-1:0]      rd_l, rd_r;
	logic                  div_start, div_done;
	logic [DW-1:0]         div_num, div_den, div_quot, div_rem;

	logic [LW-1:0]         ls_w, le_w;
	logic                  wrap_hit, span_ok;
	logic [IDX_W-1:0]      idx_w;
	logic [ADDR_BITS-1:0]  i0_w, i1_w;
	logic                  at_end;
	logic [STEP_W-1:0]     step_w;
	logic [POS_W-1:0]      pos_next;
	logic                  x_last;
	logic                  fin_go;
	logic [FADE_W-1:0]     fade_dec;
	logic [SMP_W:0]        d_w   [2];
	logic [SMP_W:0]        dmag_w[2];
	logic [S_W-1:0]        p_w   [2];
	logic [S_W-1:0]        s_w   [2];
	logic [S_W-1:0]        smag_w[2];
	logic [MW-1:0]         rsum_w[2];
	logic [Y_W-1:0]        yr_w  [2];
	logic [SMP_W-1:0]      yout_w[2];

	assign accept    = req_valid && !req_stall;
	assign load_we   = accept && (req.operation == OP_LOAD);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	wvp_ram #(.WIDTH(SMP_W), .DEPTH(1 << ADDR_BITS)) u_left_ram (
		.clk   (clk),
		.we    (load_we),
		.addr  (ram_addr),
		.wdata (req.load_left),
		.rdata (rd_l)
	);

	wvp_ram #(.WIDTH(SMP_W), .DEPTH(1 << ADDR_BITS)) u_right_ram (
		.clk   (clk),
		.we    (load_we),
		.addr  (ram_addr),
		.wdata (req.load_right),
		.rdata (rd_r)
	);

	wvp_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Loop points are 16.8 fixed point; align them to the position format.
	assign ls_w     = LW'(loop_start_q) << (FRAC_BITS - 8);
	assign le_w     = LW'(loop_end_q) << (FRAC_BITS - 8);
	assign wrap_hit = loop_en_q && (LW'(pos_q) >= le_w);
	assign span_ok  = le_w > ls_w;

	assign idx_w  = pos_w_q[LW-1:FRAC_BITS];
	assign i0_w   = idx_w[ADDR_BITS-1:0];
	assign i1_w   = i0_w + ADDR_BITS'(1);
	assign at_end = (CW'(idx_w) + CW'(1)) >= CW'(smp_len_q);

	assign step_w   = (STEP_W'(rate_q) << RATE_UP) >> RATE_DN;
	assign pos_next = pos_w_q[POS_W-1:0] + POS_W'(step_w);
	assign x_last   = (xcnt_q == XCNT_W'(XW-1));
	assign fin_go   = !rsp_valid_q || !rsp_stall;
	assign fade_dec = (fade_cnt_q != '0) ? fade_cnt_q - FADE_W'(1) : fade_cnt_q;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			d_w[c]    = (c == 0) ? ({rd_l[SMP_W-1], rd_l} - {a_q[c][SMP_W-1], a_q[c]})
			                     : ({rd_r[SMP_W-1], rd_r} - {a_q[c][SMP_W-1], a_q[c]});
			dmag_w[c] = d_w[c][SMP_W] ? -d_w[c] : d_w[c];
			p_w[c]    = dneg_q[c] ? -acc_q[c][S_W-1:0] : acc_q[c][S_W-1:0];
			s_w[c]    = {{2{a_q[c][SMP_W-1]}}, a_q[c], FRAC_BITS'(0)} + p_w[c];
			smag_w[c] = s_w[c][S_W-1] ? -s_w[c] : s_w[c];
			// Round half away from zero on the magnitude; soft mode drops one more bit.
			rsum_w[c] = acc_q[c] + (soft_q ? (MW'(1) << SH0) : (MW'(1) << (SH0 - 1)));
			yr_w[c]   = soft_q ? Y_W'(rsum_w[c] >> (SH0 + 1)) : Y_W'(rsum_w[c] >> SH0);
			yout_w[c] = sgn_q[c] ? SMP_W'(-ymag_q[c]) : SMP_W'(ymag_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = (state_q != ST_IDLE);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		ram_addr  = ADDR_BITS'(req.address);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && (req.operation == OP_TICK)) begin
					state_d = playing_q ? ST_WRAP : ST_FIN;
				end
			end
			ST_WRAP: begin
				if (wrap_hit && span_ok) begin
					div_start = 1'b1;
					div_num   = DW'(LW'(pos_q) - le_w);
					div_den   = DW'(le_w - ls_w);
					state_d   = ST_WRAP_WAIT;
				end else begin
					state_d = ST_GAIN;
				end
			end
			ST_WRAP_WAIT: begin
				if (div_done) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				div_start = 1'b1;
				div_num   = DW'(vel_q) * DW'(GAIN_SCALE) + DW'(GAIN_BIAS);
				div_den   = DW'(GAIN_DIV);
				state_d   = ST_GAIN_WAIT;
			end
			ST_GAIN_WAIT: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ram_addr = i0_w;
				state_d  = at_end ? ST_FIN : ST_RD0;
			end
			ST_RD0: begin
				ram_addr = i1_w;
				state_d  = ST_RD1;
			end
			ST_RD1: begin
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				if (x_last) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				if (x_last) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				state_d = fade_q ? ST_FMUL : ST_FIN;
			end
			ST_FMUL: begin
				if (x_last) begin
					state_d = ST_FDIV;
				end
			end
			ST_FDIV: begin
				div_start = 1'b1;
				div_num   = DW'(acc_q[ch_q]) + DW'(fade_len_q >> 1);
				div_den   = DW'(fade_len_q);
				state_d   = ST_FDIV_WAIT;
			end
			ST_FDIV_WAIT: begin
				if (div_done) begin
					state_d = ch_q ? ST_FIN : ST_FDIV;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration and voice control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q    <= 1'b0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
			smp_len_q    <= '0;
			rate_q       <= RATE_RESET;
			vel_q        <= VEL_RESET;
			soft_q       <= 1'b0;
			ign_rel_q    <= 1'b0;
			pos_q        <= '0;
			playing_q    <= 1'b0;
			releasing_q  <= 1'b0;
			fade_cnt_q   <= '0;
			fade_len_q   <= FADE_W'(1);
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LOOP_ENABLE:    loop_en_q    <= cfg_data[0];
					CFG_LOOP_START:     loop_start_q <= cfg_data[LOOP_W-1:0];
					CFG_LOOP_END:       loop_end_q   <= cfg_data[LOOP_W-1:0];
					CFG_SAMPLE_LENGTH:  smp_len_q    <= cfg_data[LEN_W-1:0];
					CFG_RATE_RATIO:     rate_q       <= cfg_data[RATE_W-1:0];
					CFG_NOTE_VELOCITY:  vel_q        <= cfg_data[VEL_W-1:0];
					CFG_SOFT_MODE:      soft_q       <= cfg_data[0];
					CFG_IGNORE_RELEASE: ign_rel_q    <= cfg_data[0];
					default: ;
				endcase
			end

			if (accept) begin
				case (req.operation)
					OP_START: begin
						pos_q       <= '0;
						playing_q   <= 1'b1;
						releasing_q <= 1'b0;
						fade_cnt_q  <= '0;
						fade_len_q  <= FADE_W'(1);
					end
					OP_RELEASE: begin
						if (playing_q && !ign_rel_q) begin
							releasing_q <= 1'b1;
							fade_len_q  <= (req.release_length == '0) ? FADE_W'(1)
							                                          : req.release_length;
							fade_cnt_q  <= (req.release_length == '0) ? FADE_W'(1)
							                                          : req.release_length;
						end
					end
					default: ;
				endcase
			end

			if (state_q == ST_CHECK && at_end) begin
				playing_q <= 1'b0;
			end

			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (state_q == ST_FIN && fin_go) begin
				rsp_valid_q <= 1'b1;
				if (active_q) begin
					pos_q <= pos_next;
					if (fade_q) begin
						fade_cnt_q <= fade_dec;
						if (fade_dec == '0) begin
							playing_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Tick datapath: channels multiply side by side; fade divides go in turn.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				fade_q   <= releasing_q && !req.sustain_held;
				active_q <= 1'b0;
			end
			ST_WRAP: begin
				pos_w_q <= wrap_hit ? ls_w : LW'(pos_q);
			end
			ST_WRAP_WAIT: begin
				if (div_done) begin
					pos_w_q <= ls_w + LW'(div_rem);
				end
			end
			ST_GAIN_WAIT: begin
				if (div_done) begin
					gain_q <= GAIN_W'(div_quot);
				end
			end
			ST_CHECK: begin
				active_q <= !at_end;
			end
			ST_RD0: begin
				a_q[0] <= rd_l;
				a_q[1] <= rd_r;
			end
			ST_RD1: begin
				for (int c = 0; c < 2; c++) begin
					dneg_q[c] <= d_w[c][SMP_W];
					mc_q[c]   <= MW'(dmag_w[c]);
					acc_q[c]  <= '0;
				end
				x_q    <= XW'(pos_w_q[FRAC_BITS-1:0]);
				xcnt_q <= '0;
			end
			ST_MUL1, ST_MUL2, ST_FMUL: begin
				for (int c = 0; c < 2; c++) begin
					if (x_q[0]) begin
						acc_q[c] <= acc_q[c] + mc_q[c];
					end
					mc_q[c] <= mc_q[c] << 1;
				end
				x_q    <= x_q >> 1;
				xcnt_q <= xcnt_q + XCNT_W'(1);
			end
			ST_SUM: begin
				for (int c = 0; c < 2; c++) begin
					sgn_q[c] <= s_w[c][S_W-1];
					mc_q[c]  <= MW'(smag_w[c]);
					acc_q[c] <= '0;
				end
				x_q    <= XW'(gain_q);
				xcnt_q <= '0;
			end
			ST_RND: begin
				for (int c = 0; c < 2; c++) begin
					ymag_q[c] <= yr_w[c];
					mc_q[c]   <= MW'(yr_w[c]);
					acc_q[c]  <= '0;
				end
				x_q    <= XW'(fade_cnt_q);
				xcnt_q <= '0;
				ch_q   <= 1'b0;
			end
			ST_FDIV_WAIT: begin
				if (div_done) begin
					ymag_q[ch_q] <= Y_W'(div_quot);
					ch_q         <= 1'b1;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					rsp_q.out_left    <= active_q ? yout_w[0] : '0;
					rsp_q.out_right   <= active_q ? yout_w[1] : '0;
					rsp_q.note_active <= active_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
